// ----- rtl/itp_pkg.sv -----
// itp_pkg: shared constants, codes and helper functions of the infix to postfix converter
// no dependencies; used by infix_to_postfix_converter
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;

    typedef logic [1:0] kind_t;
    localparam kind_t K_LETTER = 2'd0;
    localparam kind_t K_OPEN   = 2'd1;
    localparam kind_t K_CLOSE  = 2'd2;
    localparam kind_t K_OP     = 2'd3;

    // priority plus one, so that "anything else" is zero and compares stay unsigned
    typedef logic [2:0] rank_t;

    function automatic rank_t op_rank(input logic [7:0] ch);
        rank_t r;
        if (ch == CH_CARET)
            r = 3'd4;
        else if (ch == CH_STAR || ch == CH_SLASH)
            r = 3'd3;
        else if (ch == CH_PLUS || ch == CH_MINUS)
            r = 3'd2;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic kind_t classify(input logic [7:0] ch);
        kind_t k;
        if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
            k = K_LETTER;
        else if (ch == CH_LPAREN)
            k = K_OPEN;
        else if (ch == CH_RPAREN)
            k = K_CLOSE;
        else
            k = K_OP;
        return k;
    endfunction

endpackage

// ----- rtl/itp_infix_if.sv -----
// itp_infix_if: input channel of the converter, one infix character per word
// depends on nothing; used by infix_to_postfix_converter
interface itp_infix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ----- rtl/itp_postfix_if.sv -----
// itp_postfix_if: output channel of the converter, one postfix symbol per word
// depends on nothing; used by infix_to_postfix_converter
interface itp_postfix_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
    logic       overflow_seen;
    logic       unmatched_seen;

    modport source (output valid, output out_char, output out_valid, output out_last,
                    output overflow_seen, output unmatched_seen, input ready);
    modport sink   (input valid, input out_char, input out_valid, input out_last,
                    input overflow_seen, input unmatched_seen, output ready);
endinterface

// ----- rtl/infix_to_postfix_converter.sv -----
// infix_to_postfix_converter: shunting-yard converter around an operator stack memory
// depends on itp_pkg, itp_infix_if, itp_postfix_if
//
// usage
// - infix: one ascii character per word, in_last on the final character of an
//   expression; postfix: the emitted symbols, out_last on the final word of
//   an expression, an empty word (out_valid 0, out_char 0) closes an
//   expression that emits nothing at its end
// - overflow_seen and unmatched_seen are sticky and clear only at reset
// - one character at a time: infix.ready is high only between characters
// - the stack memory port (one pop per cycle while postfix does not stall,
//   read data forwarded from a push) sets the pop rate
// - a letter's word reaches postfix through the held symbol and the output register
// - the last symbol of a character is held one word back so that out_last
//   can be set on it; it leaves when the character is finished
// - a stalled postfix channel stops the pops; nothing is dropped
// - reset empties the stack by clearing its count; the memory itself is
//   not cleared and needs no clearing pass, entries are read only after
//   they were written
module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    itp_infix_if.sink            infix,
    itp_postfix_if.source        postfix
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WORK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       ch_reg, ch_next;
    logic             last_reg, last_next;
    kind_t            kind_reg, kind_next;
    rank_t            rank_reg, rank_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] paren_reg, paren_next;
    logic [7:0]       top_reg, top_next;
    logic [7:0]       below_reg;
    logic             ovf_reg, ovf_next;
    logic             unm_reg, unm_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [7:0]       pend_char_reg, pend_char_next;

    logic             ovld_reg, ovld_next;
    logic [7:0]       ochar_reg, ochar_next;
    logic             osym_reg, osym_next;
    logic             olast_reg, olast_next;
    logic             oovf_reg, oovf_next;
    logic             ounm_reg, ounm_next;

    logic [7:0]       stack_mem [STACK_DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] rd_cnt;

    logic             out_free;
    logic             top_is_open;
    logic             emit_req;
    logic             emit_ok;
    logic [7:0]       emit_char;
    logic             do_push;
    logic             do_pop;
    logic             finish;

    assign out_free    = !ovld_reg || postfix.ready;
    assign top_is_open = (top_reg == CH_LPAREN);
    assign emit_ok     = !pend_vld_reg || out_free;

    assign infix.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        kind_next      = kind_reg;
        rank_next      = rank_reg;
        unm_next       = unm_reg;
        emit_req       = 1'b0;
        emit_char      = top_reg;
        do_push        = 1'b0;
        do_pop         = 1'b0;
        finish         = 1'b0;

        ovld_next      = ovld_reg && !postfix.ready;
        ochar_next     = ochar_reg;
        osym_next      = osym_reg;
        olast_next     = olast_reg;
        oovf_next      = oovf_reg;
        ounm_next      = ounm_reg;
        pend_vld_next  = pend_vld_reg;
        pend_char_next = pend_char_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (infix.valid)
                begin
                    ch_next   = infix.in_char;
                    last_next = infix.in_last;
                    kind_next = classify(infix.in_char);
                    rank_next = op_rank(infix.in_char);
                    // no open parenthesis anywhere on the stack: the close cannot match
                    if (classify(infix.in_char) == K_CLOSE && paren_reg == '0)
                        unm_next = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                unique case (kind_reg)
                    K_LETTER:
                    begin
                        emit_req  = 1'b1;
                        emit_char = ch_reg;
                        finish    = emit_ok;
                    end
                    K_OPEN:
                    begin
                        do_push = 1'b1;
                        finish  = 1'b1;
                    end
                    K_CLOSE:
                    begin
                        if (count_reg == '0)
                            finish = 1'b1;
                        else if (top_is_open)
                        begin
                            do_pop = 1'b1;
                            finish = 1'b1;
                        end
                        else
                        begin
                            emit_req = 1'b1;
                            do_pop   = emit_ok;
                        end
                    end
                    K_OP:
                    begin
                        if (count_reg != '0 && !top_is_open && rank_reg <= op_rank(top_reg))
                        begin
                            emit_req = 1'b1;
                            do_pop   = emit_ok;
                        end
                        else
                        begin
                            do_push = 1'b1;
                            finish  = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                if (finish)
                    state_next = last_reg ? S_FLUSH : S_DONE;
            end
            S_FLUSH:
            begin
                if (count_reg != '0)
                begin
                    emit_req = 1'b1;
                    do_pop   = emit_ok;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (pend_vld_reg || last_reg)
                begin
                    if (out_free)
                    begin
                        ovld_next     = 1'b1;
                        ochar_next    = pend_vld_reg ? pend_char_reg : 8'h00;
                        osym_next     = pend_vld_reg;
                        olast_next    = last_reg;
                        oovf_next     = ovf_reg;
                        ounm_next     = unm_reg;
                        pend_vld_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new symbol pushes the held one out, never with out_last
        if (emit_req && emit_ok)
        begin
            if (pend_vld_reg)
            begin
                ovld_next  = 1'b1;
                ochar_next = pend_char_reg;
                osym_next  = 1'b1;
                olast_next = 1'b0;
                oovf_next  = ovf_reg;
                ounm_next  = unm_reg;
            end
            pend_vld_next  = 1'b1;
            pend_char_next = emit_char;
        end
    end

    // stack: top word in a register, the rest in memory, read one entry ahead
    always_comb
    begin
        count_next = count_reg;
        paren_next = paren_reg;
        top_next   = top_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        wr_addr    = IDX_W'(count_reg - CNT_W'(1));
        if (do_push)
        begin
            if (count_reg == CNT_W'(STACK_DEPTH))
                ovf_next = 1'b1;
            else
            begin
                wr_en      = (count_reg != '0);
                top_next   = ch_reg;
                count_next = count_reg + CNT_W'(1);
                if (ch_reg == CH_LPAREN)
                    paren_next = paren_reg + CNT_W'(1);
            end
        end
        else if (do_pop)
        begin
            top_next   = below_reg;
            count_next = count_reg - CNT_W'(1);
            if (top_is_open)
                paren_next = paren_reg - CNT_W'(1);
        end
    end

    assign rd_cnt  = count_next - CNT_W'(2);
    assign rd_addr = rd_cnt[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= top_reg;
        if (wr_en && wr_addr == rd_addr)
            below_reg <= top_reg;
        else
            below_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            paren_reg    <= '0;
            ovf_reg      <= 1'b0;
            unm_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            ovld_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            paren_reg    <= paren_next;
            ovf_reg      <= ovf_next;
            unm_reg      <= unm_next;
            pend_vld_reg <= pend_vld_next;
            ovld_reg     <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        last_reg      <= last_next;
        kind_reg      <= kind_next;
        rank_reg      <= rank_next;
        top_reg       <= top_next;
        pend_char_reg <= pend_char_next;
        ochar_reg     <= ochar_next;
        osym_reg      <= osym_next;
        olast_reg     <= olast_next;
        oovf_reg      <= oovf_next;
        ounm_reg      <= ounm_next;
    end

    assign postfix.valid          = ovld_reg;
    assign postfix.out_char       = ochar_reg;
    assign postfix.out_valid      = osym_reg;
    assign postfix.out_last       = olast_reg;
    assign postfix.overflow_seen  = oovf_reg;
    assign postfix.unmatched_seen = ounm_reg;

`ifndef SYNTHESIS
    a_paren_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        paren_reg <= count_reg)
        else $error("open parenthesis count exceeds stack count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (count_reg + CNT_W'(1)) == $past(count_reg))
        else $error("pop did not lower the stack count by one");

    a_empty_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        (postfix.valid && !postfix.out_valid) |-> postfix.out_last)
        else $error("empty word without out_last");

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (infix.valid && infix.ready) |-> !pend_vld_reg)
        else $error("new character accepted while a symbol is held");
`endif

endmodule
